[rtl/gimg_pkg.sv]
// ----------------------------------------------------------------------------
// gimg_pkg
// Shared types and constants of the GEM IMG line decoder: run kinds,
// configuration register indexes and the run descriptor record.
// ----------------------------------------------------------------------------
package gimg_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_PATTERN_BYTES = 2'd0;
  localparam logic [1:0] CFG_LINE_BYTES    = 2'd1;
  localparam logic [1:0] CFG_LINE_TOTAL    = 2'd2;

  // Register reset values
  localparam logic [3:0]  PATTERN_BYTES_RST = 4'd2;
  localparam logic [15:0] LINE_BYTES_RST    = 16'd80;
  localparam logic [15:0] LINE_TOTAL_RST    = 16'd400;

  // Longest pattern the block stores
  localparam int PATTERN_MAX_DEF = 8;

  // Run kinds
  localparam logic [1:0] KIND_FILL    = 2'd0;
  localparam logic [1:0] KIND_LITERAL = 2'd1;
  localparam logic [1:0] KIND_PATTERN = 2'd2;

  // Token tags
  localparam logic [7:0] TAG_PATTERN = 8'h00;
  localparam logic [7:0] TAG_BITSTR  = 8'h80;
  localparam logic [7:0] REP_MARK    = 8'hff;
  localparam logic [7:0] FILL_BLACK  = 8'hff;
  localparam logic [7:0] FILL_WHITE  = 8'h00;

  // One run descriptor
  typedef struct packed {
    logic [1:0]  run_kind;
    logic [7:0]  fill_byte;
    logic [63:0] pattern_word;
    logic [15:0] byte_count;
    logic        end_of_line;
    logic [7:0]  line_repeats;
    logic        image_done;
  } gimg_run_t;

endpackage

[rtl/gem_img_line_decoder.sv]
// ----------------------------------------------------------------------------
// gem_img_line_decoder
// Run-length decoder for GEM IMG raster lines: turns compressed bytes into
// fill, literal and pattern run descriptors with line and image marks.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_data_byte, in_image_start
//  out      output     out_valid / out_ready  out_run_kind .. out_image_done
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One byte per cycle sustained while out_ready stays high. A beat is held
//  in the input register, then the parse step writes its descriptor (if any)
//  into the output register.
//  A stalled output register holds the input register and drops in_ready
//  only once both are full, so one beat of slack covers a stall.
//  Reset (rst_n low, synchronous) clears the registers to their defaults and
//  leaves no image active: bytes are ignored until one with in_image_start.
//  Configuration writes are always taken (cfg_ready stays high).
//
module gem_img_line_decoder
  import gimg_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_image_start,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_run_kind,
  output logic [7:0]  out_fill_byte,
  output logic [63:0] out_pattern_word,
  output logic [15:0] out_byte_count,
  output logic        out_end_of_line,
  output logic [7:0]  out_line_repeats,
  output logic        out_image_done,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [3:0]  pattern_bytes_r;
  logic [15:0] line_bytes_r;
  logic [15:0] line_total_r;

  // Input register
  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  data_r;
  logic        start_r;

  // Output register
  logic        out_vld_r, out_vld_nxt;
  gimg_run_t   out_run_r;

  logic        in_take;
  logic        advance;
  logic        run_valid;
  gimg_run_t   run;

  // Advance the held beat whenever the output register is free or draining
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_take  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = run_valid;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  gimg_parse #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .data_byte     (data_r),
    .image_start   (start_r),
    .pattern_bytes (pattern_bytes_r),
    .line_bytes    (line_bytes_r),
    .line_total    (line_total_r),
    .run_valid     (run_valid),
    .run           (run)
  );

  // Control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      pattern_bytes_r <= PATTERN_BYTES_RST;
      line_bytes_r    <= LINE_BYTES_RST;
      line_total_r    <= LINE_TOTAL_RST;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PATTERN_BYTES: pattern_bytes_r <= cfg_data[3:0];
          CFG_LINE_BYTES:    line_bytes_r    <= cfg_data;
          CFG_LINE_TOTAL:    line_total_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload: capture the input beat, load the descriptor on advance
  always_ff @(posedge clk) begin
    if (in_take) begin
      data_r  <= in_data_byte;
      start_r <= in_image_start;
    end
    if (advance) begin
      out_run_r <= run;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_run_kind     = out_run_r.run_kind;
  assign out_fill_byte    = out_run_r.fill_byte;
  assign out_pattern_word = out_run_r.pattern_word;
  assign out_byte_count   = out_run_r.byte_count;
  assign out_end_of_line  = out_run_r.end_of_line;
  assign out_line_repeats = out_run_r.line_repeats;
  assign out_image_done   = out_run_r.image_done;

endmodule

[rtl/gimg_parse.sv]
// ----------------------------------------------------------------------------
// gimg_parse
// Parse state of the line decoder: takes one compressed byte per step and
// gives at most one run descriptor for it, clipped to the line.
// ----------------------------------------------------------------------------
module gimg_parse
  import gimg_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        image_start,
  input  logic [3:0]  pattern_bytes,
  input  logic [15:0] line_bytes,
  input  logic [15:0] line_total,
  output logic        run_valid,
  output gimg_run_t   run
);

  localparam int PW = 8 * PATTERN_MAX;
  localparam int IW = $clog2(PATTERN_MAX + 1);
  localparam logic [3:0] PMAX4 = 4'(PATTERN_MAX);

  typedef enum logic [3:0] {
    PH_LINE, PH_SAW0, PH_SAW00, PH_REPN, PH_TAG,
    PH_PCOUNT, PH_PATTERN, PH_LCOUNT, PH_LITERAL, PH_LSKIP
  } phase_t;

  phase_t          phase_r, phase_nxt, ph_e, em_next;
  logic [15:0]     bl_r, bl_nxt, bl_e, bl_after, em_cnt, clip_n;
  logic [15:0]     ll_r, ll_nxt, ll_e, rep16, reps16, ll_after;
  logic [7:0]      rep_r, rep_nxt, rep_e;
  logic [7:0]      tc_r, tc_nxt, tc_e;
  logic [PW-1:0]   store_r, store_nxt, store_e;
  logic [IW-1:0]   idx_r, idx_nxt, idx_e;

  logic [3:0]      plen;
  logic [PW-1:0]   pat_base_store, pat_store_w;
  logic [IW-1:0]   pat_base_idx, pat_idx_inc;
  logic [7:0]      pat_base_tc;
  logic            pat_full;
  logic [15:0]     pat_cnt;

  logic            em_en, tag_take, pat_take, lit_more, eol;
  logic [1:0]      em_kind;
  logic [7:0]      em_fill;
  logic [PW-1:0]   em_pat;

  // Pattern length, clamped to 1..PATTERN_MAX
  always_comb begin
    plen = pattern_bytes;
    if (plen == 4'd0) begin
      plen = 4'd1;
    end
    if (plen > PMAX4) begin
      plen = PMAX4;
    end
  end

  // Image start restarts all counts ahead of the byte itself
  always_comb begin
    ph_e    = image_start ? PH_LINE : phase_r;
    bl_e    = image_start ? 16'd0 : bl_r;
    ll_e    = image_start ? line_total : ll_r;
    rep_e   = image_start ? 8'd1 : rep_r;
    tc_e    = image_start ? 8'd0 : tc_r;
    store_e = image_start ? '0 : store_r;
    idx_e   = image_start ? '0 : idx_r;
  end

  // Pattern byte intake; after 00 00 y the run starts fresh with count 0
  assign pat_base_store = (ph_e == PH_SAW00) ? '0 : store_e;
  assign pat_base_idx   = (ph_e == PH_SAW00) ? '0 : idx_e;
  assign pat_base_tc    = (ph_e == PH_SAW00) ? 8'd0 : tc_e;
  assign pat_idx_inc    = pat_base_idx + IW'(1);
  assign pat_full       = (4'(pat_idx_inc) >= plen);
  assign pat_cnt        = {8'd0, pat_base_tc} * {12'd0, plen};

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pat_store_w[8*k +: 8] = (pat_base_idx == IW'(k)) ? data_byte
                                                       : pat_base_store[8*k +: 8];
    end
  end

  always_comb begin
    phase_nxt = ph_e;
    bl_nxt    = bl_e;
    ll_nxt    = ll_e;
    rep_nxt   = rep_e;
    tc_nxt    = tc_e;
    store_nxt = store_e;
    idx_nxt   = idx_e;
    em_en     = 1'b0;
    em_kind   = KIND_FILL;
    em_fill   = 8'd0;
    em_pat    = '0;
    em_cnt    = 16'd0;
    em_next   = PH_TAG;
    tag_take  = 1'b0;
    pat_take  = 1'b0;
    lit_more  = 1'b0;
    clip_n    = 16'd0;
    bl_after  = 16'd0;
    eol       = 1'b0;
    rep16     = 16'd0;
    reps16    = 16'd0;
    ll_after  = 16'd0;

    if (ll_e != 16'd0) begin
      case (ph_e)
        PH_LINE: begin
          bl_nxt  = line_bytes;
          rep_nxt = 8'd1;
          if (data_byte == 8'd0) begin
            phase_nxt = PH_SAW0;
          end else begin
            tag_take = 1'b1;
          end
        end
        PH_SAW0: begin
          if (data_byte == 8'd0) begin
            phase_nxt = PH_SAW00;
          end else begin
            tc_nxt    = data_byte;
            store_nxt = '0;
            idx_nxt   = '0;
            phase_nxt = PH_PATTERN;
          end
        end
        PH_SAW00: begin
          if (data_byte == REP_MARK) begin
            phase_nxt = PH_REPN;
          end else begin
            tc_nxt   = 8'd0;
            pat_take = 1'b1;
          end
        end
        PH_REPN: begin
          rep_nxt   = (data_byte == 8'd0) ? 8'd1 : data_byte;
          phase_nxt = PH_TAG;
        end
        PH_TAG: begin
          tag_take = 1'b1;
        end
        PH_PCOUNT: begin
          tc_nxt    = data_byte;
          store_nxt = '0;
          idx_nxt   = '0;
          phase_nxt = PH_PATTERN;
        end
        PH_PATTERN: begin
          pat_take = 1'b1;
        end
        PH_LCOUNT: begin
          tc_nxt    = data_byte;
          phase_nxt = (data_byte == 8'd0) ? PH_TAG : PH_LITERAL;
        end
        PH_LITERAL: begin
          tc_nxt   = tc_e - 8'd1;
          em_en    = 1'b1;
          em_kind  = KIND_LITERAL;
          em_fill  = data_byte;
          em_cnt   = 16'd1;
          lit_more = (tc_nxt != 8'd0);
        end
        PH_LSKIP: begin
          tc_nxt = tc_e - 8'd1;
          if (tc_nxt == 8'd0) begin
            phase_nxt = PH_LINE;
          end
        end
        default: begin
          phase_nxt = PH_LINE;
        end
      endcase
    end

    // Token tag: pattern run, bit string or solid run
    if (tag_take) begin
      if (data_byte == TAG_PATTERN) begin
        phase_nxt = PH_PCOUNT;
      end else if (data_byte == TAG_BITSTR) begin
        phase_nxt = PH_LCOUNT;
      end else begin
        em_en   = 1'b1;
        em_kind = KIND_FILL;
        em_fill = data_byte[7] ? FILL_BLACK : FILL_WHITE;
        em_cnt  = {9'd0, data_byte[6:0]};
      end
    end

    if (pat_take) begin
      store_nxt = pat_store_w;
      idx_nxt   = pat_idx_inc;
      if (pat_full) begin
        em_en   = 1'b1;
        em_kind = KIND_PATTERN;
        em_pat  = pat_store_w;
        em_cnt  = pat_cnt;
      end else begin
        phase_nxt = PH_PATTERN;
      end
    end

    // Clip to the line; close the line when it is full
    if (em_en) begin
      clip_n   = (em_cnt > bl_nxt) ? bl_nxt : em_cnt;
      bl_after = bl_nxt - clip_n;
      bl_nxt   = bl_after;
      eol      = (bl_after == 16'd0);
      if (eol) begin
        rep16     = {8'd0, (rep_nxt == 8'd0) ? 8'd1 : rep_nxt};
        reps16    = (rep16 > ll_nxt) ? ll_nxt : rep16;
        ll_after  = ll_nxt - reps16;
        ll_nxt    = ll_after;
        rep_nxt   = 8'd1;
        phase_nxt = PH_LINE;
      end else begin
        phase_nxt = em_next;
      end
    end

    // Bit string continues, or its tail past the line is skipped
    if (lit_more) begin
      phase_nxt = (phase_nxt == PH_LINE) ? PH_LSKIP : PH_LITERAL;
    end
  end

  assign run_valid        = em_en;
  assign run.run_kind     = em_kind;
  assign run.fill_byte    = em_fill;
  assign run.pattern_word = 64'(em_pat);
  assign run.byte_count   = clip_n;
  assign run.end_of_line  = eol;
  assign run.line_repeats = reps16[7:0];
  assign run.image_done   = eol && (ll_after == 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE;
      bl_r    <= 16'd0;
      ll_r    <= 16'd0;
      rep_r   <= 8'd1;
      tc_r    <= 8'd0;
      store_r <= '0;
      idx_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bl_r    <= bl_nxt;
      ll_r    <= ll_nxt;
      rep_r   <= rep_nxt;
      tc_r    <= tc_nxt;
      store_r <= store_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eol_reps : assert property (@(posedge clk) disable iff (!rst_n)
    step && run_valid && run.end_of_line |-> run.line_repeats != 8'd0)
    else $error("line closed with zero repeats");

  a_mid_line : assert property (@(posedge clk) disable iff (!rst_n)
    step && run_valid && !run.end_of_line |-> run.line_repeats == 8'd0 && !run.image_done)
    else $error("repeats or image done on a run inside a line");

  a_done_stop : assert property (@(posedge clk) disable iff (!rst_n)
    step && run_valid && run.image_done |=> ll_r == 16'd0)
    else $error("lines left after image done");

  a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IW'(PATTERN_MAX))
    else $error("pattern index beyond pattern store");
`endif

endmodule

[test/gem_img_line_decoder_tb.sv]
// ----------------------------------------------------------------------------
// gem_img_line_decoder_tb
// Self-checking bench for the GEM IMG line decoder. A scoreboard class keeps
// its own copy of the parse state and the registers, predicts the run
// descriptor of every accepted byte and checks each output beat against the
// oldest prediction. Stimulus is a short directed stream followed by random
// images (headers, pattern runs, bit strings, solid runs, noise) over several
// register settings and three idling regimes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gem_img_line_decoder_tb;
  import gimg_pkg::*;

  // Hang guard: a run still going at CYCLE_LIMIT is reported as failing.
  localparam int CYCLE_LIMIT = 400000;

  // Parse states of the byte stream
  typedef enum logic [3:0] {
    ST_LINE,       // first byte of a line
    ST_SAW0,       // line began with 00
    ST_SAW00,      // line began with 00 00
    ST_REP_N,      // repeat count byte of a header
    ST_TAG,        // next token tag
    ST_PAT_COUNT,  // count byte of a pattern run
    ST_PAT_BYTES,  // pattern bytes
    ST_LIT_COUNT,  // count byte of a bit string
    ST_LIT_BYTES,  // literal bytes inside the line
    ST_LIT_SKIP    // literal bytes past the line end
  } parse_state_t;

  // One input beat waiting to be sent
  typedef struct packed {
    logic [7:0] dbyte;
    logic       img_start;
  } beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: run descriptor predictor plus the queue of pending runs
  // --------------------------------------------------------------------------
  class run_scoreboard;
    logic [3:0]   pat_len_reg;
    logic [15:0]  line_len_reg;
    logic [15:0]  line_cnt_reg;
    parse_state_t st;
    logic [15:0]  left_in_line;
    logic [15:0]  lines_to_go;
    logic [7:0]   line_rep;
    logic [7:0]   run_len;
    logic [63:0]  pat_acc;
    logic [3:0]   pat_pos;
    gimg_run_t    want_runs[$];
    int           mismatches;

    function new();
      pat_len_reg  = PATTERN_BYTES_RST;
      line_len_reg = LINE_BYTES_RST;
      line_cnt_reg = LINE_TOTAL_RST;
      st           = ST_LINE;
      left_in_line = '0;
      lines_to_go  = '0;
      line_rep     = 8'd1;
      run_len      = '0;
      pat_acc      = '0;
      pat_pos      = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_PATTERN_BYTES: pat_len_reg = val[3:0];
        CFG_LINE_BYTES:    line_len_reg = val;
        CFG_LINE_TOTAL:    line_cnt_reg = val;
        default: ;
      endcase
    endfunction

    // Pattern length as the block applies it: 0 acts as 1, clamp at the max
    function int unsigned eff_pat_len();
      int unsigned p;
      p = {28'd0, pat_len_reg};
      if (p == 0) p = 1;
      if (p > PATTERN_MAX_DEF) p = PATTERN_MAX_DEF;
      return p;
    endfunction

    function bit active();
      return lines_to_go != 0;
    endfunction

    function bit at_line_start();
      return st == ST_LINE;
    endfunction

    function int pending();
      return want_runs.size();
    endfunction

    // Clip the run to the line, close the line when it is full
    function void emit_run(logic [1:0] kind, logic [7:0] fill, logic [63:0] pat,
                           int unsigned count, parse_state_t nxt);
      gimg_run_t   r;
      int unsigned n;
      int unsigned reps;
      n = (count > left_in_line) ? left_in_line : count;
      left_in_line = left_in_line - n[15:0];
      r = '0;
      r.run_kind     = kind;
      r.fill_byte    = fill;
      r.pattern_word = pat;
      r.byte_count   = n[15:0];
      if (left_in_line == 0) begin
        reps = (line_rep == 0) ? 1 : line_rep;
        if (reps > lines_to_go) reps = lines_to_go;
        lines_to_go = lines_to_go - reps[15:0];
        line_rep = 8'd1;
        r.end_of_line  = 1'b1;
        r.line_repeats = reps[7:0];
        r.image_done   = (lines_to_go == 0);
        st = ST_LINE;
      end else begin
        st = nxt;
      end
      want_runs.push_back(r);
    endfunction

    function void load_pattern(logic [7:0] cnt);
      run_len = cnt;
      pat_acc = '0;
      pat_pos = '0;
      st      = ST_PAT_BYTES;
    endfunction

    function void take_pat(logic [7:0] b);
      pat_acc = pat_acc | ({56'd0, b} << (8 * pat_pos[2:0]));
      pat_pos = pat_pos + 4'd1;
      if (pat_pos >= eff_pat_len())
        emit_run(KIND_PATTERN, 8'h00, pat_acc, run_len * eff_pat_len(), ST_TAG);
      else
        st = ST_PAT_BYTES;
    endfunction

    function void take_tag(logic [7:0] b);
      if (b == TAG_PATTERN)
        st = ST_PAT_COUNT;
      else if (b == TAG_BITSTR)
        st = ST_LIT_COUNT;
      else
        emit_run(KIND_FILL, b[7] ? FILL_BLACK : FILL_WHITE, 64'd0, {25'd0, b[6:0]},
                 ST_TAG);
    endfunction

    // Advance by one accepted byte; return 1 when the byte was not ignored
    function bit note_beat(logic [7:0] b, logic s);
      if (s) begin
        lines_to_go  = line_cnt_reg;
        st           = ST_LINE;
        line_rep     = 8'd1;
        run_len      = '0;
        pat_acc      = '0;
        pat_pos      = '0;
        left_in_line = '0;
      end
      if (lines_to_go == 0) return 1'b0;
      case (st)
        ST_LINE: begin
          left_in_line = line_len_reg;
          line_rep     = 8'd1;
          if (b == TAG_PATTERN) st = ST_SAW0;
          else take_tag(b);
        end
        ST_SAW0: begin
          if (b == TAG_PATTERN) st = ST_SAW00;
          else load_pattern(b);
        end
        ST_SAW00: begin
          if (b == REP_MARK) begin
            st = ST_REP_N;
          end else begin
            load_pattern(8'd0);
            take_pat(b);
          end
        end
        ST_REP_N: begin
          line_rep = (b == 0) ? 8'd1 : b;
          st = ST_TAG;
        end
        ST_TAG:       take_tag(b);
        ST_PAT_COUNT: load_pattern(b);
        ST_PAT_BYTES: take_pat(b);
        ST_LIT_COUNT: begin
          run_len = b;
          st = (b == 0) ? ST_TAG : ST_LIT_BYTES;
        end
        ST_LIT_BYTES: begin
          run_len = run_len - 8'd1;
          emit_run(KIND_LITERAL, b, 64'd0, 1, ST_TAG);
          if (run_len != 0) st = (st == ST_LINE) ? ST_LIT_SKIP : ST_LIT_BYTES;
        end
        ST_LIT_SKIP: begin
          run_len = run_len - 8'd1;
          if (run_len == 0) st = ST_LINE;
        end
        default: st = ST_LINE;
      endcase
      return 1'b1;
    endfunction

    function string show(gimg_run_t r);
      return $sformatf("kind=%0d fill=%02h pat=%016h count=%0d eol=%0b reps=%0d done=%0b",
                       r.run_kind, r.fill_byte, r.pattern_word, r.byte_count,
                       r.end_of_line, r.line_repeats, r.image_done);
    endfunction

    function void check_run(gimg_run_t got);
      gimg_run_t want;
      if (want_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected run descriptor: %s", show(got));
        return;
      end
      want = want_runs.pop_front();
      if (got.run_kind !== want.run_kind || got.fill_byte !== want.fill_byte ||
          got.pattern_word !== want.pattern_word || got.byte_count !== want.byte_count ||
          got.end_of_line !== want.end_of_line || got.line_repeats !== want.line_repeats ||
          got.image_done !== want.image_done) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("run descriptor mismatch");
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_image_start = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_run_kind;
  logic [7:0]  out_fill_byte;
  logic [63:0] out_pattern_word;
  logic [15:0] out_byte_count;
  logic        out_end_of_line;
  logic [7:0]  out_line_repeats;
  logic        out_image_done;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gem_img_line_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_image_start   (in_image_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_run_kind     (out_run_kind),
    .out_fill_byte    (out_fill_byte),
    .out_pattern_word (out_pattern_word),
    .out_byte_count   (out_byte_count),
    .out_end_of_line  (out_end_of_line),
    .out_line_repeats (out_line_repeats),
    .out_image_done   (out_image_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  run_scoreboard sb;
  int            tx_idle_pct = 0;   // chance per beat slot that the sender idles
  int            rx_idle_pct = 0;   // chance per cycle that the receiver stalls
  int            long_stall = 0;    // cycles of forced out_ready low, set by main
  int            cycles = 0;
  bit            last_live;         // last accepted byte was not ignored
  bit            new_image;         // next planned byte opens an image
  beat_t         beat_q[$];         // planned bytes of the current token

  // --------------------------------------------------------------------------
  // Hang guard
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gem_img_line_decoder regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: check every output beat, then pick out_ready for the next cycle.
  // A long stall is counted down here while the sender keeps pushing.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_run({out_run_kind, out_fill_byte, out_pattern_word, out_byte_count,
                    out_end_of_line, out_line_repeats, out_image_done});
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_stall > 0) begin
      long_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender: idle at random, then offer one beat and hold it until accepted.
  // Valid stays high into the next beat unless the sender idles.
  // --------------------------------------------------------------------------
  task automatic send_beat(logic [7:0] b, logic s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_image_start <= s;
    do @(posedge clk); while (!in_ready);
    last_live = sb.note_beat(b, s);
  endtask

  // Drop valid and wait until every predicted run has come out, plus settle
  // cycles for a byte still in flight that yields no run.
  task automatic drain(int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
    repeat (settle) @(posedge clk);
  endtask

  // Write one register; cfg_valid stays high so back-to-back writes need
  // only one assignment per edge. The caller drops it after the last one.
  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(logic [3:0] pb, logic [15:0] lb, logic [15:0] lt);
    drain(4);
    cfg_write(CFG_PATTERN_BYTES, {12'd0, pb});
    cfg_write(CFG_LINE_BYTES, lb);
    cfg_write(CFG_LINE_TOTAL, lt);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Token planner: mostly well-formed tokens with random content, headers at
  // line starts, a new image once the last one is done, some noise.
  // --------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    beat_q.push_back('{dbyte: b, img_start: new_image});
    new_image = 1'b0;
  endfunction

  function automatic void plan_token();
    int unsigned pick;
    int unsigned cnt;
    logic [7:0]  tag;
    if (!sb.active() && !new_image) begin
      // image over: sometimes feed a byte that must be ignored
      if ($urandom_range(3) == 0) begin
        push_byte(8'($urandom_range(255)));
        return;
      end
      new_image = 1'b1;
    end
    if ((new_image || sb.at_line_start()) && $urandom_range(3) == 0) begin
      push_byte(TAG_PATTERN);
      push_byte(TAG_PATTERN);
      push_byte(REP_MARK);
      pick = $urandom_range(9);
      if (pick == 0) push_byte(8'd0);
      else if (pick == 1) push_byte(8'd1);
      else if (pick < 8) push_byte(8'($urandom_range(4, 2)));
      else push_byte(8'($urandom_range(255)));
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      // noise, now and then restarting the image mid-stream
      beat_q.push_back('{dbyte: 8'($urandom_range(255)),
                         img_start: new_image | ($urandom_range(29) == 0)});
      new_image = 1'b0;
    end else if (pick < 50) begin
      tag = 8'($urandom_range(255, 1));
      if (tag == TAG_BITSTR) tag = tag ^ 8'h01;
      push_byte(tag);
    end else if (pick < 75) begin
      push_byte(TAG_PATTERN);
      cnt = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(4);
      push_byte(cnt[7:0]);
      repeat (sb.eff_pat_len()) push_byte(8'($urandom_range(255)));
    end else begin
      push_byte(TAG_BITSTR);
      cnt = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(6);
      push_byte(cnt[7:0]);
      repeat (cnt) push_byte(8'($urandom_range(255)));
    end
  endfunction

  // Send until n bytes were consumed (ignored bytes do not count); cap the
  // beats so a setting that ignores everything still moves on.
  task automatic run_items(int n);
    int    live;
    int    beats;
    beat_t bt;
    live  = 0;
    beats = 0;
    while (live < n && beats < 4 * n) begin
      if (beat_q.size() == 0) plan_token();
      bt = beat_q.pop_front();
      send_beat(bt.dbyte, bt.img_start);
      beats++;
      if (last_live) live++;
    end
  endtask

  task automatic run_phase(logic [3:0] pb, logic [15:0] lb, logic [15:0] lt, int n);
    set_config(pb, lb, lt);
    beat_q.delete();
    new_image = 1'b1;
    run_items(n);
  endtask

  // Directed stream at reset settings (2 pattern bytes, 80 bytes, 400 lines):
  // byte before any image, header with repeat 3, clipped white run closing
  // the line, header look-ahead into a count-0 pattern, pattern run, empty bit
  // string, two literals, clipped black run, header with repeat 0, black run.
  localparam logic [8:0] DIRECTED [26] = '{
    9'h085,
    9'h100, 9'h000, 9'h0ff, 9'h003,
    9'h07f,
    9'h000, 9'h000, 9'h005, 9'h0aa,
    9'h000, 9'h003, 9'h011, 9'h022,
    9'h080, 9'h000,
    9'h080, 9'h002, 9'h0ff, 9'h000,
    9'h0ff,
    9'h000, 9'h000, 9'h0ff, 9'h000,
    9'h081
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles 27 %, receiver 46 %
    tx_idle_pct = 27;
    rx_idle_pct = 46;
    foreach (DIRECTED[i]) send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);

    run_phase(4'd1, 16'd1, 16'd1, 90);
    // hold the receiver off while the sender keeps offering: fill and stall
    set_config(4'd8, 16'd24, 16'd3);
    beat_q.delete();
    new_image = 1'b1;
    long_stall = 300;
    run_items(110);
    run_phase(4'd0, 16'd0, 16'd2, 60);
    run_phase(4'd15, 16'hffff, 16'hffff, 60);

    // sender idles 46 %, receiver 27 %
    tx_idle_pct = 46;
    rx_idle_pct = 27;
    run_phase(4'd3, 16'd16, 16'd0, 10);
    run_phase(4'd5, 16'd40, 16'd4, 55);
    // pause the sender until the block is empty, then go on
    drain(0);
    run_items(55);
    run_phase(4'd2, 16'd12, 16'd2, 100);
    run_phase(4'($urandom_range(15)), 16'($urandom_range(48, 1)),
              16'($urandom_range(6, 1)), 100);

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(4'd8, 16'd1, 16'hffff, 60);
    run_phase(4'd6, 16'd30, 16'd5, 120);
    repeat (3)
      run_phase(4'($urandom_range(15)), 16'($urandom_range(48, 1)),
                16'($urandom_range(6, 1)), 80);

    // let the last beats through the pipeline
    drain(8);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("gem_img_line_decoder regression: pass");
    else
      $display("gem_img_line_decoder regression: fail");
    $finish;
  end

endmodule
